// ===== rtl/windowed_bandwidth_tx_mux_assert.svh =====
// Assertion macros used by the transmit multiplexer RTL.
`ifndef WINDOWED_BANDWIDTH_TX_MUX_ASSERT_SVH
`define WINDOWED_BANDWIDTH_TX_MUX_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define WBTM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define WBTM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/wbtm_pkg.sv =====
// Types, constants and the region lookup function of the transmit multiplexer.
package wbtm_pkg;

    localparam int CLIENT_COUNT = 3;
    localparam int CLIENT_W     = 2;

    // Size of one client's buffer region in bytes, and the longest frame.
    localparam logic [31:0] REGION_SIZE = 32'd2097152;
    localparam int          MAX_LENGTH  = 2048;

    // Operation codes of an input item.
    localparam logic [1:0] OP_TX    = 2'd0;
    localparam logic [1:0] OP_DONE  = 2'd1;
    localparam logic [1:0] OP_TIMER = 2'd2;

    // Status codes of a result item.
    localparam logic [2:0] ST_FORWARD     = 3'd0;
    localparam logic [2:0] ST_HELD_BUDGET = 3'd1;
    localparam logic [2:0] ST_HELD_FULL   = 3'd2;
    localparam logic [2:0] ST_RETURNED    = 3'd3;
    localparam logic [2:0] ST_BAD         = 3'd4;
    localparam logic [2:0] ST_TIMER       = 3'd5;

    // Configuration register indexes.
    typedef logic [2:0] cfg_idx_t;
    localparam cfg_idx_t CFG_WINDOW_LENGTH = 3'd0;
    localparam cfg_idx_t CFG_BIT_LIMIT0    = 3'd1;
    localparam cfg_idx_t CFG_BIT_LIMIT1    = 3'd2;
    localparam cfg_idx_t CFG_BIT_LIMIT2    = 3'd3;
    localparam cfg_idx_t CFG_REGION_MAP0   = 3'd4;
    localparam cfg_idx_t CFG_REGION_MAP1   = 3'd5;
    localparam cfg_idx_t CFG_REGION_MAP2   = 3'd6;

    // Reset values of the configuration registers.
    localparam logic [31:0] WINDOW_LENGTH_RST = 32'd10000;
    localparam logic [30:0] BIT_LIMIT0_RST    = 31'd100000000;
    localparam logic [30:0] BIT_LIMIT1_RST    = 31'd1000000;
    localparam logic [30:0] BIT_LIMIT2_RST    = 31'd100000000;

    typedef logic [CLIENT_COUNT-1:0][63:0] region_map_t;
    typedef logic [CLIENT_COUNT-1:0][30:0] bit_limit_t;

    // One client's accounting entry as kept in the state memory.
    typedef struct packed {
        logic        pending;
        logic [31:0] bits_used;
        logic [63:0] window_start;
    } entry_t;

    // Outcome of a region search.
    typedef struct packed {
        logic                hit;
        logic [CLIENT_W-1:0] client;
        logic [31:0]         addr;
    } lookup_t;

    // Search the regions in client order; the lowest client that holds addr wins.
    function automatic lookup_t region_lookup(logic [31:0] addr, logic use_virt,
                                              region_map_t map);
        lookup_t     res;
        logic [31:0] from_base;
        logic [31:0] to_base;
        logic [32:0] diff;
        res = '0;
        for (int c = CLIENT_COUNT - 1; c >= 0; c--)
        begin
            from_base = use_virt ? map[c][63:32] : map[c][31:0];
            to_base   = use_virt ? map[c][31:0]  : map[c][63:32];
            diff      = {1'b0, addr} - {1'b0, from_base};
            if (!diff[32] && (diff[31:0] < REGION_SIZE))
            begin
                res.hit    = 1'b1;
                res.client = CLIENT_W'(c);
                res.addr   = to_base + diff[31:0];
            end
        end
        return res;
    endfunction

endpackage

// ===== rtl/wbtm_if.sv =====
// Request and result channel interfaces of the transmit multiplexer.
interface wbtm_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [1:0]  client;
    logic [31:0] buffer_addr;
    logic [11:0] frame_length;
    logic [63:0] now;
    logic        driver_full;

    modport source (output valid, op, client, buffer_addr, frame_length, now, driver_full,
                    input ready);
    modport sink (input valid, op, client, buffer_addr, frame_length, now, driver_full,
                  output ready);
endinterface

interface wbtm_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [31:0] out_addr;
    logic [11:0] out_length;
    logic [1:0]  out_client;
    logic        timeout_request;
    logic [31:0] timeout_value;

    modport source (output valid, status, out_addr, out_length, out_client,
                    timeout_request, timeout_value, input ready);
    modport sink (input valid, status, out_addr, out_length, out_client,
                  timeout_request, timeout_value, output ready);
endinterface

// ===== rtl/wbtm_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module wbtm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // A read at the address being written returns the old contents.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/windowed_bandwidth_tx_mux.sv =====
// Pipeline: stage one registers an accepted item and its state memory read; the result
// register takes its result once free or being emptied (read, then update).
// Throughput: one item per cycle while results flow; state memory is read at accept and
// written back as it leaves, the last write forwarded for back-to-back same-client items.
// Reset: configuration returns to its defaults, the pipeline empties, and per-client
// valid bits make every state entry read as zero until it is first written.
`include "windowed_bandwidth_tx_mux_assert.svh"

module windowed_bandwidth_tx_mux (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  wbtm_pkg::cfg_idx_t cfg_index,
    input  logic [63:0]        cfg_data,
    wbtm_req_if.sink           req,
    wbtm_rsp_if.source         rsp
);

    import wbtm_pkg::*;

    // Configuration registers.
    logic [31:0] window_length_reg;
    bit_limit_t  bit_limit_reg;
    region_map_t region_map_reg;

    // Pipeline control.
    logic                     s1_valid_reg;
    logic                     fwd_reg;
    logic                     out_valid_reg;
    logic [CLIENT_COUNT-1:0]  entry_valid_reg;
    logic                     in_ready;
    logic                     in_fire;
    logic                     s1_adv;

    // Stage one payload.
    logic [1:0]          s1_op_reg;
    logic [1:0]          s1_client_reg;
    logic [11:0]         s1_len_reg;
    logic [63:0]         s1_now_reg;
    logic                s1_full_reg;
    lookup_t             s1_lk_reg;
    entry_t              last_wr_reg;

    // State memory access.
    logic [CLIENT_W-1:0] rd_addr;
    logic [CLIENT_W-1:0] s1_idx;
    logic                ram_we;
    logic [$bits(entry_t)-1:0] ram_rdata;
    lookup_t             lk_first;

    // Update logic.
    entry_t      cur_entry;
    entry_t      new_entry;
    logic        wr_req;
    logic [63:0] elapsed_raw;
    logic        expired;
    logic [31:0] bu_eff;
    logic [63:0] ws_eff;
    logic [31:0] tval_eff;
    logic        over_budget;
    logic        len_bad;
    logic [32:0] bits_sum;
    logic [31:0] bits_sat;
    lookup_t     lk_second;

    // Result register.
    logic [2:0]  st_next,    st_reg;
    logic [31:0] addr_next,  addr_reg;
    logic [11:0] len_next,   len_reg;
    logic [1:0]  cli_next,   cli_reg;
    logic        treq_next,  treq_reg;
    logic [31:0] tval_next,  tval_reg;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_length_reg <= WINDOW_LENGTH_RST;
            bit_limit_reg[0]  <= BIT_LIMIT0_RST;
            bit_limit_reg[1]  <= BIT_LIMIT1_RST;
            bit_limit_reg[2]  <= BIT_LIMIT2_RST;
            region_map_reg    <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_WINDOW_LENGTH: window_length_reg <= cfg_data[31:0];
                CFG_BIT_LIMIT0:    bit_limit_reg[0]  <= cfg_data[30:0];
                CFG_BIT_LIMIT1:    bit_limit_reg[1]  <= cfg_data[30:0];
                CFG_BIT_LIMIT2:    bit_limit_reg[2]  <= cfg_data[30:0];
                CFG_REGION_MAP0:   region_map_reg[0] <= cfg_data;
                CFG_REGION_MAP1:   region_map_reg[1] <= cfg_data;
                CFG_REGION_MAP2:   region_map_reg[2] <= cfg_data;
                default:           ;
            endcase
        end
    end

    // Handshake: stage one moves on when the result register is free or being emptied.
    assign s1_adv    = s1_valid_reg && (!out_valid_reg || rsp.ready);
    assign in_ready  = !s1_valid_reg || s1_adv;
    assign in_fire   = req.valid && in_ready;
    assign req.ready = in_ready;

    // An out-of-range client reads entry zero; its result never uses the entry.
    assign rd_addr = (req.client < CLIENT_W'(CLIENT_COUNT)) ? req.client : '0;
    assign s1_idx  = (s1_client_reg < CLIENT_W'(CLIENT_COUNT)) ? s1_client_reg : '0;

    // First region search on the incoming address, virtual for transmit.
    assign lk_first = region_lookup(req.buffer_addr, req.op == OP_TX, region_map_reg);

    wbtm_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (CLIENT_COUNT)
    ) u_state_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (s1_idx),
        .wdata (new_entry),
        .re    (in_fire),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    // Stage one control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            fwd_reg         <= 1'b0;
            entry_valid_reg <= '0;
        end
        else
        begin
            if (in_fire)
            begin
                s1_valid_reg <= 1'b1;
                fwd_reg      <= ram_we && (s1_idx == rd_addr);
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (ram_we)
            begin
                entry_valid_reg[s1_idx] <= 1'b1;
            end
        end
    end

    // Stage one payload and the copy of the last entry written.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_op_reg     <= req.op;
            s1_client_reg <= req.client;
            s1_len_reg    <= req.frame_length;
            s1_now_reg    <= req.now;
            s1_full_reg   <= req.driver_full;
            s1_lk_reg     <= lk_first;
        end
        if (ram_we)
        begin
            last_wr_reg <= new_entry;
        end
    end

    // Current entry: forwarded write, memory data, or zero before the first write.
    always_comb
    begin
        if (fwd_reg)
        begin
            cur_entry = last_wr_reg;
        end
        else if (entry_valid_reg[s1_idx])
        begin
            cur_entry = entry_t'(ram_rdata);
        end
        else
        begin
            cur_entry = '0;
        end
    end

    // Window check, budget and counter arithmetic.
    assign elapsed_raw = s1_now_reg - cur_entry.window_start;
    assign expired     = elapsed_raw >= {32'd0, window_length_reg};
    assign bu_eff      = expired ? 32'd0 : cur_entry.bits_used;
    assign ws_eff      = expired ? s1_now_reg : cur_entry.window_start;
    assign tval_eff    = expired ? window_length_reg : (window_length_reg - elapsed_raw[31:0]);
    assign over_budget = bu_eff >= {1'b0, bit_limit_reg[s1_idx]};
    assign len_bad     = 32'(s1_len_reg) > 32'(MAX_LENGTH);
    assign bits_sum    = {1'b0, bu_eff} + {18'd0, s1_len_reg, 3'd0};
    assign bits_sat    = bits_sum[32] ? '1 : bits_sum[31:0];

    // Second search: owner of the virtual address found for a completion.
    assign lk_second = region_lookup(s1_lk_reg.addr, 1'b1, region_map_reg);

    // Result and write-back selection.
    always_comb
    begin
        st_next   = ST_BAD;
        addr_next = '0;
        len_next  = '0;
        cli_next  = '0;
        treq_next = 1'b0;
        tval_next = '0;
        new_entry = cur_entry;
        wr_req    = 1'b0;
        unique case (s1_op_reg)
            OP_TX:
            begin
                len_next = s1_len_reg;
                cli_next = s1_client_reg;
                if (s1_client_reg < CLIENT_W'(CLIENT_COUNT))
                begin
                    wr_req                 = 1'b1;
                    new_entry.window_start = ws_eff;
                    new_entry.bits_used    = bu_eff;
                    if (len_bad)
                    begin
                        st_next = ST_BAD;
                    end
                    else if (s1_full_reg || over_budget)
                    begin
                        st_next = s1_full_reg ? ST_HELD_FULL : ST_HELD_BUDGET;
                        if (!cur_entry.pending)
                        begin
                            new_entry.pending = 1'b1;
                            treq_next         = 1'b1;
                            tval_next         = tval_eff;
                        end
                    end
                    else if (!s1_lk_reg.hit)
                    begin
                        st_next = ST_BAD;
                    end
                    else
                    begin
                        new_entry.bits_used = bits_sat;
                        st_next             = ST_FORWARD;
                        addr_next           = s1_lk_reg.addr;
                    end
                end
            end
            OP_DONE:
            begin
                len_next = s1_len_reg;
                if (s1_lk_reg.hit && lk_second.hit)
                begin
                    st_next   = ST_RETURNED;
                    addr_next = s1_lk_reg.addr;
                    cli_next  = lk_second.client;
                end
            end
            OP_TIMER:
            begin
                st_next  = ST_TIMER;
                cli_next = s1_client_reg;
                if (s1_client_reg < CLIENT_W'(CLIENT_COUNT))
                begin
                    wr_req            = 1'b1;
                    new_entry.pending = 1'b0;
                end
            end
            default:
            begin
                st_next = ST_BAD;
            end
        endcase
    end

    assign ram_we = s1_adv && wr_req;

    // Result register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result register payload.
    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            st_reg   <= st_next;
            addr_reg <= addr_next;
            len_reg  <= len_next;
            cli_reg  <= cli_next;
            treq_reg <= treq_next;
            tval_reg <= tval_next;
        end
    end

    assign rsp.valid           = out_valid_reg;
    assign rsp.status          = st_reg;
    assign rsp.out_addr        = addr_reg;
    assign rsp.out_length      = len_reg;
    assign rsp.out_client      = cli_reg;
    assign rsp.timeout_request = treq_reg;
    assign rsp.timeout_value   = tval_reg;

    // A write-back happens only as its item leaves stage one.
    `WBTM_ASSERT_NOW(a_write_on_advance, clk, rst_n, ram_we, s1_adv,
        "state written without an item leaving stage one")

    // A back-to-back item for the same client must take the forwarded entry.
    `WBTM_ASSERT_NEXT(a_forward_taken, clk, rst_n, in_fire && ram_we && (s1_idx == rd_addr),
        fwd_reg && s1_valid_reg, "same-client follow-up did not select the forwarded entry")

    // A waiting result is never overwritten.
    `WBTM_ASSERT_NOW(a_no_overwrite, clk, rst_n, out_valid_reg && !rsp.ready, !s1_adv,
        "stage one advanced into a stalled result register")

    // A timeout is only requested for a held packet.
    `WBTM_ASSERT_NOW(a_timeout_on_hold, clk, rst_n, out_valid_reg && treq_reg,
        (st_reg == ST_HELD_BUDGET) || (st_reg == ST_HELD_FULL),
        "timeout requested for an item that was not held")

endmodule

// ===== tb/windowed_bandwidth_tx_mux_tb.sv =====
// Self-checking testbench for the windowed bandwidth transmit multiplexer.
module windowed_bandwidth_tx_mux_tb;

    import wbtm_pkg::*;

    // Cycles with no accepted item on either channel before the run is abandoned.
    localparam int IDLE_LIMIT = 2000;

    // Cycles to let pass after the last expected result before the next test starts.
    localparam int SETTLE_CYCLES = 4;

    // One transmit, completion or timer descriptor.
    typedef struct packed {
        logic [1:0]  op;
        logic [1:0]  client;
        logic [31:0] buffer_addr;
        logic [11:0] frame_length;
        logic [63:0] now;
        logic        driver_full;
    } tx_desc_t;

    // One result item of the multiplexer.
    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] out_addr;
        logic [11:0] out_length;
        logic [1:0]  out_client;
        logic        timeout_request;
        logic [31:0] timeout_value;
    } mux_reply_t;

    // Ways the result side applies backpressure.
    typedef enum logic [1:0] {
        SINK_STEADY,
        SINK_SLOW,
        SINK_SPARSE,
        SINK_RANDOM
    } sink_mode_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    cfg_idx_t cfg_index;
    logic [63:0] cfg_data;

    wbtm_req_if req_ch();
    wbtm_rsp_if rsp_ch();

    windowed_bandwidth_tx_mux dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    // Shadow copy of the configuration registers.
    logic [31:0] m_window_len;
    logic [30:0] m_bit_limit [CLIENT_COUNT];
    logic [63:0] m_region [CLIENT_COUNT];

    // Shadow copy of the per-client accounting state.
    logic [63:0] m_win_start [CLIENT_COUNT];
    logic [31:0] m_bits_used [CLIENT_COUNT];
    logic        m_armed [CLIENT_COUNT];

    mux_reply_t replies_due [$];
    mux_reply_t got_reply;
    mux_reply_t want_reply;
    int error_count;
    int idle_cycles;
    int burst_left;
    bit req_live;
    sink_mode_t sink_mode;
    int sink_left;
    int sink_phase;

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #10 clk = ~clk;
        end
    end

    // Search the regions in client order; the lowest client holding addr wins.
    function automatic bit find_region(input logic [31:0] addr, input bit use_virt,
                                       output logic [1:0] owner, output logic [31:0] xlat);
        logic [31:0] from_base;
        logic [31:0] to_base;
        owner = '0;
        xlat  = '0;
        for (int c = 0; c < CLIENT_COUNT; c++)
        begin
            from_base = use_virt ? m_region[c][63:32] : m_region[c][31:0];
            to_base   = use_virt ? m_region[c][31:0]  : m_region[c][63:32];
            if (addr >= from_base && (addr - from_base) < REGION_SIZE)
            begin
                owner = 2'(c);
                xlat  = to_base + (addr - from_base);
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // Work out the result of one accepted item and advance the shadow state.
    function automatic mux_reply_t predict_reply(tx_desc_t d);
        mux_reply_t  r;
        logic [63:0] age;
        logic [32:0] sum;
        logic [31:0] xlat;
        logic [31:0] back;
        logic [1:0]  owner;
        logic [1:0]  owner_virt;
        r = '0;
        r.status = ST_BAD;
        if (d.op == OP_TX)
        begin
            r.out_length = d.frame_length;
            r.out_client = d.client;
            if (d.client < CLIENT_COUNT)
            begin
                // An expired window restarts with an empty bit count.
                if (d.now - m_win_start[d.client] >= 64'(m_window_len))
                begin
                    m_bits_used[d.client] = '0;
                    m_win_start[d.client] = d.now;
                end
                age = d.now - m_win_start[d.client];
                if (d.frame_length > MAX_LENGTH)
                    r.status = ST_BAD;
                else if (d.driver_full || m_bits_used[d.client] >= 32'(m_bit_limit[d.client]))
                begin
                    r.status = d.driver_full ? ST_HELD_FULL : ST_HELD_BUDGET;
                    if (!m_armed[d.client])
                    begin
                        m_armed[d.client]  = 1'b1;
                        r.timeout_request = 1'b1;
                        r.timeout_value   = m_window_len - age[31:0];
                    end
                end
                else if (find_region(d.buffer_addr, 1'b1, owner, xlat))
                begin
                    sum = {1'b0, m_bits_used[d.client]} + 33'({d.frame_length, 3'b000});
                    m_bits_used[d.client] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                    r.status   = ST_FORWARD;
                    r.out_addr = xlat;
                end
            end
        end
        else if (d.op == OP_DONE)
        begin
            // The returned virtual address must itself land in a virtual region.
            r.out_length = d.frame_length;
            if (find_region(d.buffer_addr, 1'b0, owner, back))
            begin
                if (find_region(back, 1'b1, owner_virt, xlat))
                begin
                    r.status     = ST_RETURNED;
                    r.out_addr   = back;
                    r.out_client = owner_virt;
                end
            end
        end
        else if (d.op == OP_TIMER)
        begin
            r.status     = ST_TIMER;
            r.out_client = d.client;
            if (d.client < CLIENT_COUNT)
                m_armed[d.client] = 1'b0;
        end
        return r;
    endfunction

    function automatic tx_desc_t make_desc(logic [1:0] op, logic [1:0] client,
                                           logic [31:0] addr, logic [11:0] len,
                                           logic [63:0] now, logic full);
        tx_desc_t d;
        d.op           = op;
        d.client       = client;
        d.buffer_addr  = addr;
        d.frame_length = len;
        d.now          = now;
        d.driver_full  = full;
        return d;
    endfunction

    // Write one configuration register while the block is idle.
    task automatic write_reg(cfg_idx_t idx, logic [63:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        case (idx)
            CFG_WINDOW_LENGTH: m_window_len   = value[31:0];
            CFG_BIT_LIMIT0:    m_bit_limit[0] = value[30:0];
            CFG_BIT_LIMIT1:    m_bit_limit[1] = value[30:0];
            CFG_BIT_LIMIT2:    m_bit_limit[2] = value[30:0];
            CFG_REGION_MAP0:   m_region[0]    = value;
            CFG_REGION_MAP1:   m_region[1]    = value;
            CFG_REGION_MAP2:   m_region[2]    = value;
            default:           ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // Offer one item, predict its result once accepted, then pace the next one.
    task automatic send_item(tx_desc_t d);
        req_ch.valid        <= 1'b1;
        req_ch.op           <= d.op;
        req_ch.client       <= d.client;
        req_ch.buffer_addr  <= d.buffer_addr;
        req_ch.frame_length <= d.frame_length;
        req_ch.now          <= d.now;
        req_ch.driver_full  <= d.driver_full;
        req_live = 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (req_ch.ready !== 1'b1);
        replies_due.push_back(predict_reply(d));
        @(negedge clk);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            req_ch.valid <= 1'b0;
            req_live = 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                      : $urandom_range(0, 12);
        end
    endtask

    // Hold the sender off until every expected result has come back.
    task automatic drain_replies();
        if (req_live)
        begin
            req_ch.valid <= 1'b0;
            req_live = 1'b0;
        end
        while (replies_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    function automatic logic [11:0] random_length();
        case ($urandom_range(0, 9))
            0:       return 12'(MAX_LENGTH);
            1:       return 12'($urandom_range(MAX_LENGTH + 1, 4095));
            default: return 12'($urandom_range(0, MAX_LENGTH));
        endcase
    endfunction

    function automatic logic [30:0] random_limit();
        case ($urandom_range(0, 5))
            0:       return 31'd0;
            1:       return 31'h7FFF_FFFF;
            default: return 31'($urandom_range(8192, 200000));
        endcase
    endfunction

    // Region maps: fully random, near the top of the address space, or aligned.
    function automatic logic [63:0] random_region();
        case ($urandom_range(0, 3))
            0:       return {$urandom, $urandom};
            1:       return {32'hFFF0_0000 + $urandom_range(0, 32'h000F_FFFF), $urandom};
            2:       return {$urandom, 32'hFFF0_0000 + $urandom_range(0, 32'h000F_FFFF)};
            default: return {$urandom & 32'hFFE0_0000, $urandom & 32'hFFE0_0000};
        endcase
    endfunction

    // Reset configuration: edges of the default regions, hold and error cases.
    task automatic test_default_settings();
        send_item(make_desc(OP_TX, 2'd0, 32'h0000_0000, 12'd0, 64'd0, 1'b0));
        send_item(make_desc(OP_TX, 2'd1, 32'h001F_FFFF, 12'd2048, 64'd5, 1'b0));
        send_item(make_desc(OP_TX, 2'd2, 32'h0020_0000, 12'd100, 64'd6, 1'b0));
        send_item(make_desc(OP_TX, 2'd0, 32'h0000_1000, 12'd2049, 64'd7, 1'b0));
        send_item(make_desc(OP_TX, 2'd1, 32'h0000_2000, 12'd64, 64'd12, 1'b1));
        send_item(make_desc(OP_TX, 2'd1, 32'h0000_2000, 12'd64, 64'd13, 1'b1));
        send_item(make_desc(OP_TIMER, 2'd1, 32'h0, 12'd0, 64'd14, 1'b0));
        send_item(make_desc(OP_TX, 2'd3, 32'h0000_0040, 12'd64, 64'd15, 1'b0));
        send_item(make_desc(OP_TIMER, 2'd3, 32'h0, 12'd0, 64'd16, 1'b0));
        send_item(make_desc(2'd3, 2'd3, 32'hFFFF_FFFF, 12'hFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1));
        send_item(make_desc(OP_DONE, 2'd0, 32'h0000_1234, 12'd1500, 64'd18, 1'b0));
        send_item(make_desc(OP_DONE, 2'd2, 32'hFFFF_FFFF, 12'd60, 64'd19, 1'b0));
        drain_replies();
    endtask

    // Exhausted budgets, window restart, overlapping and wrapping regions, time wrap.
    task automatic test_budget_and_window();
        write_reg(CFG_WINDOW_LENGTH, 64'd100);
        write_reg(CFG_BIT_LIMIT0, 64'd0);
        write_reg(CFG_BIT_LIMIT1, 64'd16384);
        write_reg(CFG_BIT_LIMIT2, 64'h7FFF_FFFF);
        write_reg(CFG_REGION_MAP0, 64'h1000_0000_8000_0000);
        write_reg(CFG_REGION_MAP1, 64'hFFF0_0000_0010_0000);
        write_reg(CFG_REGION_MAP2, 64'h1010_0000_FFFF_F000);
        send_item(make_desc(OP_TX, 2'd0, 32'h1000_0010, 12'd64, 64'd1000, 1'b0));
        send_item(make_desc(OP_TX, 2'd1, 32'h1010_0000, 12'd2048, 64'd1010, 1'b0));
        send_item(make_desc(OP_TX, 2'd1, 32'h1010_0000, 12'd1, 64'd1020, 1'b0));
        send_item(make_desc(OP_TX, 2'd1, 32'hFFFF_FFFF, 12'd1, 64'd1110, 1'b0));
        send_item(make_desc(OP_TX, 2'd2, 32'h1020_0000, 12'd2048, 64'd1110, 1'b0));
        send_item(make_desc(OP_DONE, 2'd0, 32'h0020_0000, 12'd77, 64'd1111, 1'b0));
        send_item(make_desc(OP_DONE, 2'd0, 32'h8000_0040, 12'd64, 64'd1112, 1'b0));
        send_item(make_desc(OP_DONE, 2'd0, 32'h0000_0100, 12'd64, 64'd1113, 1'b0));
        send_item(make_desc(OP_TX, 2'd2, 32'h1020_0000, 12'd64, 64'hFFFF_FFFF_FFFF_FFF0, 1'b0));
        send_item(make_desc(OP_TX, 2'd2, 32'h1020_0000, 12'd64, 64'd5, 1'b1));
        drain_replies();
    endtask

    // Largest window and limits, all-ones and all-zero region maps.
    task automatic test_register_extremes();
        write_reg(CFG_WINDOW_LENGTH, 64'hFFFF_FFFF);
        write_reg(CFG_BIT_LIMIT0, 64'h7FFF_FFFF);
        write_reg(CFG_BIT_LIMIT1, 64'h7FFF_FFFF);
        write_reg(CFG_BIT_LIMIT2, 64'h7FFF_FFFF);
        write_reg(CFG_REGION_MAP0, 64'h0);
        write_reg(CFG_REGION_MAP1, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(CFG_REGION_MAP2, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(make_desc(OP_TIMER, 2'd0, 32'h0, 12'd0, 64'd1006, 1'b0));
        send_item(make_desc(OP_TX, 2'd0, 32'h0000_0000, 12'd64, 64'd1007, 1'b1));
        send_item(make_desc(OP_TX, 2'd2, 32'hFFFF_FFFF, 12'd2048, 64'd1008, 1'b0));
        send_item(make_desc(OP_DONE, 2'd0, 32'hFFFF_FFFF, 12'd2048, 64'd1009, 1'b0));
        drain_replies();
    endtask

    // Mostly well-formed traffic into the mapped regions with advancing time, plus noise.
    task automatic test_random_traffic(logic [31:0] win, logic [63:0] t0, int n_items);
        tx_desc_t    d;
        logic [63:0] t;
        int unsigned pick;
        int unsigned step_cap;
        int          region;
        write_reg(CFG_WINDOW_LENGTH, {32'd0, win});
        write_reg(CFG_BIT_LIMIT0, {33'd0, random_limit()});
        write_reg(CFG_BIT_LIMIT1, {33'd0, random_limit()});
        write_reg(CFG_BIT_LIMIT2, {33'd0, random_limit()});
        write_reg(CFG_REGION_MAP0, random_region());
        write_reg(CFG_REGION_MAP1, random_region());
        write_reg(CFG_REGION_MAP2, random_region());
        // Time steps scale with the window so that budgets and restarts both occur.
        step_cap = (win / 6 > 200000) ? 200000 : win / 6;
        if (step_cap == 0)
            step_cap = 1;
        t = t0;
        for (int i = 0; i < n_items; i++)
        begin
            t      = t + $urandom_range(0, step_cap);
            region = $urandom_range(0, CLIENT_COUNT - 1);
            pick   = $urandom_range(0, 99);
            d = make_desc(OP_TX, 2'($urandom_range(0, CLIENT_COUNT - 1)),
                          m_region[region][63:32] + $urandom_range(0, REGION_SIZE - 1),
                          random_length(), t, $urandom_range(0, 9) == 0);
            if (pick >= 88)
            begin
                d.op           = 2'($urandom_range(0, 3));
                d.client       = 2'($urandom_range(0, 3));
                d.buffer_addr  = $urandom;
                d.frame_length = 12'($urandom_range(0, 4095));
                d.driver_full  = 1'($urandom_range(0, 1));
                if ($urandom_range(0, 1) == 1)
                    d.now = {$urandom, $urandom};
            end
            else if (pick >= 76)
            begin
                d.op     = OP_TIMER;
                d.client = ($urandom_range(0, 15) == 0) ? 2'd3
                                                        : 2'($urandom_range(0, CLIENT_COUNT - 1));
            end
            else if (pick >= 60)
            begin
                d.op          = OP_DONE;
                d.buffer_addr = m_region[region][31:0] + $urandom_range(0, REGION_SIZE - 1);
            end
            send_item(d);
        end
        drain_replies();
    endtask

    // Compare one field of a result item.
    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            error_count++;
        end
    endtask

    // Result checker: each accepted result against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
        begin
            got_reply.status          = rsp_ch.status;
            got_reply.out_addr        = rsp_ch.out_addr;
            got_reply.out_length      = rsp_ch.out_length;
            got_reply.out_client      = rsp_ch.out_client;
            got_reply.timeout_request = rsp_ch.timeout_request;
            got_reply.timeout_value   = rsp_ch.timeout_value;
            if (replies_due.size() == 0)
            begin
                $error("result item with none expected: status %0d", got_reply.status);
                error_count++;
            end
            else
            begin
                want_reply = replies_due.pop_front();
                check_field("status", 32'(want_reply.status), 32'(got_reply.status));
                check_field("out_addr", want_reply.out_addr, got_reply.out_addr);
                check_field("out_length", 32'(want_reply.out_length), 32'(got_reply.out_length));
                check_field("out_client", 32'(want_reply.out_client), 32'(got_reply.out_client));
                check_field("timeout_request", 32'(want_reply.timeout_request),
                            32'(got_reply.timeout_request));
                check_field("timeout_value", want_reply.timeout_value, got_reply.timeout_value);
            end
        end
    end

    // Result backpressure: steady, fixed patterns and random stalls, switched now and then.
    always @(negedge clk)
    begin
        if (sink_left == 0)
        begin
            sink_mode = sink_mode_t'($urandom_range(0, 3));
            sink_left = $urandom_range(16, 160);
        end
        sink_left--;
        sink_phase++;
        case (sink_mode)
            SINK_STEADY: rsp_ch.ready <= 1'b1;
            SINK_SLOW:   rsp_ch.ready <= (sink_phase % 8) >= 3;
            SINK_SPARSE: rsp_ch.ready <= (sink_phase % 5) != 0;
            default:     rsp_ch.ready <= 1'($urandom_range(0, 1));
        endcase
    end

    // Watchdog on cycles in which neither channel moves an item.
    always @(posedge clk)
    begin
        if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
            (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("windowed_bandwidth_tx_mux_tb: done, errors");
            $finish;
        end
    end

    // Test sequence.
    initial
    begin
        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_index           = CFG_WINDOW_LENGTH;
        cfg_data            = '0;
        req_ch.valid        = 1'b0;
        req_ch.op           = OP_TX;
        req_ch.client       = '0;
        req_ch.buffer_addr  = '0;
        req_ch.frame_length = '0;
        req_ch.now          = '0;
        req_ch.driver_full  = 1'b0;
        rsp_ch.ready        = 1'b0;
        error_count         = 0;
        idle_cycles         = 0;
        burst_left          = 0;
        req_live            = 1'b0;
        sink_mode           = SINK_STEADY;
        sink_left           = 0;
        sink_phase          = 0;

        // Shadow state matches the block after reset.
        m_window_len = WINDOW_LENGTH_RST;
        m_bit_limit[0] = BIT_LIMIT0_RST;
        m_bit_limit[1] = BIT_LIMIT1_RST;
        m_bit_limit[2] = BIT_LIMIT2_RST;
        for (int c = 0; c < CLIENT_COUNT; c++)
        begin
            m_region[c]    = '0;
            m_win_start[c] = '0;
            m_bits_used[c] = '0;
            m_armed[c]     = 1'b0;
        end

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        test_default_settings();
        test_budget_and_window();
        test_register_extremes();
        test_random_traffic(32'd1, 64'd0, 300);
        test_random_traffic(32'd5000, 64'd200000, 300);
        test_random_traffic(32'd200, 64'hFFFF_FFFF_FFFF_C000, 300);
        test_random_traffic(32'hFFFF_FFFF, {$urandom, $urandom}, 300);
        test_random_traffic(32'($urandom_range(2, 20000)), {$urandom, $urandom}, 300);

        if (replies_due.size() != 0)
        begin
            $error("%0d expected result items never arrived", replies_due.size());
            error_count++;
        end
        if (error_count == 0)
            $display("windowed_bandwidth_tx_mux_tb: done, clean");
        else
            $display("windowed_bandwidth_tx_mux_tb: done, errors");
        $finish;
    end

endmodule

// ===== windowed_bandwidth_tx_mux.f =====
+incdir+rtl
rtl/wbtm_pkg.sv
rtl/wbtm_if.sv
rtl/wbtm_ram.sv
rtl/windowed_bandwidth_tx_mux.sv
tb/windowed_bandwidth_tx_mux_tb.sv
